// ===== rtl/gbd_pkg.sv =====
// shared types, widths and helpers for the gompertz birth-death step
`timescale 1ns / 1ps
package gbd_pkg;

  localparam int POP_W   = 24;
  localparam int COEF_W  = 24;
  localparam int TIME_W  = 32;
  localparam int GIDX_W  = 10;
  localparam int CNT_W   = 11;
  localparam int LOG_W   = 25;  // 5 integer bits, 20 fraction bits
  localparam int LND_W   = 26;
  localparam int NL_W    = 25;
  localparam int FX_W    = 48;
  localparam int BIRTH_W = 53;
  localparam int TOTAL_W = 54;
  localparam int DVD_W   = 41;
  localparam int POS_W   = 42;
  localparam int HI_W    = 55;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [GIDX_W-1:0] GP_MAX = 10'd1023;
  localparam logic [POP_W-1:0] POP_MAX = 24'hFFFFFF;
  localparam logic [TIME_W-1:0] TIME_MAX = 32'hFFFFFFFF;

  localparam logic [CFG_IDX_W-1:0] REG_DIV_COEF   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEATH_COEF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_POP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_STEP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_PTS   = 3'd5;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LOAD, CMD_START, CMD_PREP, CMD_LOG_K, CMD_SAVE_LK, CMD_LOG_X,
    CMD_LNKX, CMD_BIRTH_LO, CMD_BIRTH_HI, CMD_TOTAL, CMD_ZINC, CMD_ZFIN, CMD_LOG_U,
    CMD_NL, CMD_DIV, CMD_TIME, CMD_GINC, CMD_PICK_LO, CMD_PICK_HI, CMD_APPLY, CMD_OUT
  } cmd_t;

  typedef struct packed {
    logic op;
    logic running;
    logic birth_path;
    logic total_zero;
    logic fill_more;
    logic grid_more;
    logic log_busy;
    logic div_busy;
    logic out_free;
  } status_t;

  // natural log from a q.20 log2 value
  function automatic logic [NL_W-1:0] ln_q20(input logic [LND_W-1:0] d);
    logic [LND_W+31:0] p;
    p = d * LN2_Q32;
    return p[NL_W+31:32];
  endfunction

endpackage

// ===== rtl/gompertz_birth_death_ssa_step.sv =====
// top level of the gompertz birth-death stochastic step engine
//
//   channel | ports                      | contents
//   in      | in_tvalid/in_tready        | tuser: operation; tdata: uniform_time, uniform_pick
//   out     | out_tvalid/out_tready      | tdata: pop_after .. finished
//   cfg     | cfg_wr_en/cfg_index/wdata  | one register write per cycle
//
// a start request or a request while stopped goes from dispatch straight to the result register.
// a step with births is dominated by three log2 passes on a shared unit (a normalize
// phase of one shift per bit, then 20 squarings each) and a restoring divide (41
// quotient bits), with one grid increment per grid point passed. a step with deaths
// only skips two log2 passes; a zero-rate step fills the rest of the grid, one grid
// point at a time. reset is synchronous and needs no clearing.
// a waiting result is held while out_tready is low; the next request is taken meanwhile.
`timescale 1ns / 1ps
module gompertz_birth_death_ssa_step import gbd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [63:0]          in_tdata,   // uniform_time[31:0], uniform_pick[63:32]
  input  logic [0:0]           in_tuser,   // operation[0]
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // pop_after[23:0], held_pop[47:24], grid_first[57:48], grid_count[68:58],
  // time_after[100:69], finished[101]
  output logic [103:0]         out_tdata,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  cmd_t    cmd;
  status_t status;

  gbd_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .status(status), .cmd(cmd)
  );

  gbd_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tready(out_tready), .out_tvalid(out_tvalid), .out_tdata(out_tdata),
    .cmd(cmd), .status(status)
  );

endmodule

// ===== rtl/gbd_log2.sv =====
// iterative log2 unit: normalize one bit a cycle, then one squaring a cycle
`timescale 1ns / 1ps
module gbd_log2 import gbd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [31:0]      operand,
  output logic             busy,
  output logic [LOG_W-1:0] result
);

  typedef enum logic [1:0] {L_IDLE, L_NORM, L_SQR} lphase_t;

  lphase_t     phase_r;
  logic [31:0] m_r;
  logic [4:0]  e_r;
  logic [19:0] frac_r;
  logic [4:0]  cnt_r;
  logic [63:0] sq;

  assign sq     = m_r * m_r;
  assign busy   = (phase_r != L_IDLE);
  assign result = {e_r, frac_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= L_IDLE;
      e_r     <= '0;
      frac_r  <= '0;
    end else begin
      unique case (phase_r)
        L_IDLE: begin
          if (start) begin
            m_r    <= operand;
            frac_r <= '0;
            cnt_r  <= '0;
            if (operand == '0) begin
              e_r <= '0;
            end else begin
              e_r     <= 5'd31;
              phase_r <= L_NORM;
            end
          end
        end
        L_NORM: begin
          if (m_r[31]) begin
            phase_r <= L_SQR;
          end else begin
            m_r <= {m_r[30:0], 1'b0};
            e_r <= e_r - 5'd1;
          end
        end
        L_SQR: begin
          // (m*m)>>31, renormalized when it reaches two
          frac_r <= {frac_r[18:0], sq[63]};
          m_r    <= sq[63] ? sq[63:32] : sq[62:31];
          cnt_r  <= cnt_r + 5'd1;
          if (cnt_r == 5'd19) begin
            phase_r <= L_IDLE;
          end
        end
        default: phase_r <= L_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/gbd_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module gbd_div import gbd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DVD_W-1:0]   dividend,
  input  logic [TOTAL_W-1:0] divisor,
  output logic               busy,
  output logic [DVD_W-1:0]   quotient
);

  logic [TOTAL_W:0]   rem_r;
  logic [DVD_W-1:0]   q_r;
  logic [5:0]         cnt_r;
  logic               busy_r;
  logic [TOTAL_W:0]   trial;
  logic               fits;

  assign trial    = {rem_r[TOTAL_W-1:0], q_r[DVD_W-1]};
  assign fits     = (trial >= {1'b0, divisor});
  assign busy     = busy_r;
  assign quotient = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      rem_r  <= '0;
      q_r    <= dividend;
      cnt_r  <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? (trial - {1'b0, divisor}) : trial;
      q_r   <= {q_r[DVD_W-2:0], fits};
      cnt_r <= cnt_r + 6'd1;
      if (cnt_r == 6'(DVD_W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/gbd_dp.sv =====
// datapath: registers, state, rate arithmetic, grid walk and result register
`timescale 1ns / 1ps
module gbd_dp import gbd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  input  logic [63:0]          in_tdata,
  input  logic [0:0]           in_tuser,
  input  logic                 out_tready,
  output logic                 out_tvalid,
  output logic [103:0]         out_tdata,
  input  cmd_t                 cmd,
  output status_t              status
);

  logic [COEF_W-1:0] div_coef_r, death_coef_r;
  logic [POP_W-1:0]  cap_r, init_pop_r;
  logic [31:0]       grid_step_r;
  logic [GIDX_W-1:0] grid_pts_r;

  logic [POP_W-1:0]  pop_r, held_r;
  logic [TIME_W-1:0] time_r, t_r;
  logic [GIDX_W-1:0] gidx_r, first_r;
  logic              running_r, op_r, sat_r, lo_zero_r, out_valid_r;
  logic [31:0]       u1_r, u2_r;
  logic [LOG_W-1:0]  lk_r;
  logic [NL_W-1:0]   lnkx_r, nl_r;
  logic [FX_W-1:0]   fx_r, death_r;
  logic [BIRTH_W-1:0] birth_r;
  logic [62:0]       bacc_r;
  logic [TOTAL_W-1:0] total_r;
  logic [POS_W-1:0]  gpos_r, end_r;
  logic [63:0]       p2_r;
  logic [HI_W-1:0]   hi_r;
  logic [101:0]      out_r;

  logic [GIDX_W-1:0] gp;
  logic              log_start, log_busy, div_start, div_busy;
  logic [31:0]       log_opnd;
  logic [LOG_W-1:0]  log_res;
  logic [DVD_W-1:0]  dt;
  logic [37:0]       fx_sh;
  logic [43:0]       bhi_prod;
  logic [62:0]       birth_full;
  logic [POS_W-1:0]  t_sum;
  logic [53:0]       p1;
  logic              divide;
  logic [POP_W-1:0]  pop_new;
  logic [CNT_W-1:0]  count;

  assign gp = (grid_pts_r > GP_MAX) ? GP_MAX : grid_pts_r;

  always_comb begin
    unique case (cmd)
      CMD_LOG_K: log_opnd = {8'b0, cap_r};
      CMD_LOG_X: log_opnd = {8'b0, pop_r};
      default:   log_opnd = (u1_r == '0) ? 32'd1 : u1_r;
    endcase
  end
  assign log_start = (cmd == CMD_LOG_K) || (cmd == CMD_LOG_X) || (cmd == CMD_LOG_U);
  assign div_start = (cmd == CMD_DIV);

  gbd_log2 u_log2 (
    .clk(clk), .rst_n(rst_n), .start(log_start), .operand(log_opnd),
    .busy(log_busy), .result(log_res)
  );

  gbd_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend({nl_r, 16'b0}),
    .divisor(total_r), .busy(div_busy), .quotient(dt)
  );

  assign fx_sh      = fx_r[FX_W-1:10];
  assign bhi_prod   = fx_sh[37:19] * lnkx_r;
  assign birth_full = {bhi_prod, 19'b0} + bacc_r;
  assign t_sum      = {10'b0, time_r} + {1'b0, dt};
  assign p1         = u2_r * total_r[TOTAL_W-1:32];
  assign divide     = (hi_r < {2'b0, birth_r}) || ((hi_r == {2'b0, birth_r}) && lo_zero_r);
  assign count      = {1'b0, gidx_r} - {1'b0, first_r};

  always_comb begin
    if (divide) begin
      pop_new = (pop_r < POP_MAX) ? pop_r + 24'd1 : pop_r;
    end else begin
      pop_new = (pop_r != '0) ? pop_r - 24'd1 : pop_r;
    end
  end

  always_comb begin
    status.op         = op_r;
    status.running    = running_r;
    status.birth_path = (pop_r < cap_r) && (pop_r != '0);
    status.total_zero = (birth_r == '0) && (death_r == '0);
    status.fill_more  = (gidx_r < gp);
    status.grid_more  = (gidx_r < gp) && (sat_r || ({10'b0, t_r} > gpos_r));
    status.log_busy   = log_busy;
    status.div_busy   = div_busy;
    status.out_free   = !out_valid_r || out_tready;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_coef_r   <= 24'd1048576;
      death_coef_r <= '0;
      cap_r        <= 24'd100000;
      init_pop_r   <= 24'd100;
      grid_step_r  <= 32'd6554;
      grid_pts_r   <= 10'd300;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_DIV_COEF:   div_coef_r   <= cfg_wdata[COEF_W-1:0];
        REG_DEATH_COEF: death_coef_r <= cfg_wdata[COEF_W-1:0];
        REG_CAPACITY:   cap_r        <= cfg_wdata[POP_W-1:0];
        REG_INIT_POP:   init_pop_r   <= cfg_wdata[POP_W-1:0];
        REG_GRID_STEP:  grid_step_r  <= cfg_wdata;
        REG_GRID_PTS:   grid_pts_r   <= cfg_wdata[GIDX_W-1:0];
        default: ;
      endcase
    end
  end

  // realization state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pop_r     <= '0;
      time_r    <= '0;
      gidx_r    <= '0;
      running_r <= 1'b0;
    end else begin
      unique case (cmd)
        CMD_START: begin
          pop_r     <= init_pop_r;
          time_r    <= '0;
          gidx_r    <= 10'd1;
          running_r <= (init_pop_r != '0) && (gp != '0) && (grid_step_r != '0);
        end
        CMD_ZINC, CMD_GINC: gidx_r <= gidx_r + 10'd1;
        CMD_ZFIN: begin
          time_r    <= TIME_MAX;
          running_r <= 1'b0;
        end
        CMD_APPLY: begin
          pop_r     <= pop_new;
          time_r    <= t_r;
          running_r <= !((pop_new == '0) || sat_r || ({10'b0, t_r} >= end_r));
        end
        default: ;
      endcase
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_LOAD: begin
        op_r    <= in_tuser[0];
        u1_r    <= in_tdata[31:0];
        u2_r    <= in_tdata[63:32];
        first_r <= gidx_r;
        held_r  <= '0;
      end
      CMD_START: begin
        first_r <= '0;
        held_r  <= init_pop_r;
      end
      CMD_PREP: begin
        gpos_r  <= POS_W'(gidx_r * grid_step_r);
        end_r   <= POS_W'(gp * grid_step_r);
        fx_r    <= div_coef_r * pop_r;
        death_r <= death_coef_r * pop_r;
        birth_r <= '0;
      end
      CMD_SAVE_LK: lk_r <= log_res;
      CMD_LNKX: lnkx_r <= (lk_r > log_res) ? ln_q20({1'b0, lk_r - log_res}) : '0;
      CMD_BIRTH_LO: bacc_r <= 63'(fx_sh[18:0] * lnkx_r);
      CMD_BIRTH_HI: birth_r <= birth_full[62:10];
      CMD_TOTAL: total_r <= {1'b0, birth_r} + {6'b0, death_r};
      CMD_ZFIN: held_r <= pop_r;
      CMD_NL: nl_r <= ln_q20((LND_W'(1) << 25) - {1'b0, log_res});
      CMD_TIME: begin
        if (t_sum >= {10'b0, TIME_MAX}) begin
          t_r   <= TIME_MAX;
          sat_r <= 1'b1;
        end else begin
          t_r   <= t_sum[TIME_W-1:0];
          sat_r <= 1'b0;
        end
      end
      CMD_GINC: begin
        gpos_r <= gpos_r + {10'b0, grid_step_r};
        held_r <= pop_r;
      end
      CMD_PICK_LO: p2_r <= u2_r * total_r[31:0];
      CMD_PICK_HI: begin
        hi_r      <= {1'b0, p1} + {23'b0, p2_r[63:32]};
        lo_zero_r <= (p2_r[31:0] == '0);
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd == CMD_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_OUT) begin
      out_r <= {!running_r, time_r, count, first_r, held_r, pop_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b0, out_r};

endmodule

// ===== rtl/gbd_ctrl.sv =====
// controller: sequences one start or step request through the datapath
`timescale 1ns / 1ps
module gbd_ctrl import gbd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_LOGK, S_LOGKW, S_LOGX, S_LOGXW, S_BLO, S_BHI, S_TOTAL,
    S_ZFILL, S_LOGU, S_LOGUW, S_NL, S_DIV, S_DIVW, S_GRID, S_PHI, S_APPLY, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd       = CMD_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        priority if (!status.op) begin
          cmd       = CMD_START;
          state_nxt = S_OUT;
        end else if (!status.running) begin
          state_nxt = S_OUT;
        end else begin
          cmd       = CMD_PREP;
          state_nxt = status.birth_path ? S_LOGK : S_TOTAL;
        end
      end
      S_LOGK: begin
        cmd       = CMD_LOG_K;
        state_nxt = S_LOGKW;
      end
      S_LOGKW: begin
        if (!status.log_busy) begin
          cmd       = CMD_SAVE_LK;
          state_nxt = S_LOGX;
        end
      end
      S_LOGX: begin
        cmd       = CMD_LOG_X;
        state_nxt = S_LOGXW;
      end
      S_LOGXW: begin
        if (!status.log_busy) begin
          cmd       = CMD_LNKX;
          state_nxt = S_BLO;
        end
      end
      S_BLO: begin
        cmd       = CMD_BIRTH_LO;
        state_nxt = S_BHI;
      end
      S_BHI: begin
        cmd       = CMD_BIRTH_HI;
        state_nxt = S_TOTAL;
      end
      S_TOTAL: begin
        cmd       = CMD_TOTAL;
        state_nxt = status.total_zero ? S_ZFILL : S_LOGU;
      end
      S_ZFILL: begin
        // no reaction can fire: report the rest of the grid
        if (status.fill_more) begin
          cmd = CMD_ZINC;
        end else begin
          cmd       = CMD_ZFIN;
          state_nxt = S_OUT;
        end
      end
      S_LOGU: begin
        cmd       = CMD_LOG_U;
        state_nxt = S_LOGUW;
      end
      S_LOGUW: begin
        if (!status.log_busy) begin
          cmd       = CMD_NL;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd       = CMD_DIV;
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (!status.div_busy) begin
          cmd       = CMD_TIME;
          state_nxt = S_GRID;
        end
      end
      S_GRID: begin
        if (status.grid_more) begin
          cmd = CMD_GINC;
        end else begin
          cmd       = CMD_PICK_LO;
          state_nxt = S_PHI;
        end
      end
      S_PHI: begin
        cmd       = CMD_PICK_HI;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        cmd       = CMD_APPLY;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd       = CMD_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== tb/gompertz_birth_death_ssa_step_tb.sv =====
// self-checking testbench for the gompertz birth-death stochastic step engine
`timescale 1ns / 1ps
module gompertz_birth_death_ssa_step_tb;
  import gbd_pkg::*;

  typedef struct {
    logic        op;
    logic [31:0] u_time;
    logic [31:0] u_pick;
  } req_t;

  typedef struct {
    logic [POP_W-1:0]  pop_after;
    logic [POP_W-1:0]  held_pop;
    logic [GIDX_W-1:0] grid_first;
    logic [CNT_W-1:0]  grid_count;
    logic [TIME_W-1:0] time_after;
    logic              finished;
  } step_res_t;

  localparam int WATCHDOG_LIMIT = 50000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [63:0] in_tdata = '0;  // uniform_time[31:0], uniform_pick[63:32]
  logic [0:0] in_tuser = '0;   // operation[0]
  logic out_tvalid;
  logic out_tready = 1'b0;
  // pop_after[23:0], held_pop[47:24], grid_first[57:48], grid_count[68:58],
  // time_after[100:69], finished[101]
  logic [103:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  gompertz_birth_death_ssa_step u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // register shadow and engine state
  longint unsigned coef_f, coef_g, capacity, init_pop, grid_step, grid_pts;
  longint unsigned cur_pop, cur_time;
  int unsigned cur_gidx;
  bit is_running;

  req_t pending_reqs[$];
  step_res_t pending_results[$];
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;

  function automatic longint unsigned log2_frac(input longint unsigned v);
    int unsigned e;
    longint unsigned m, frac;
    e = 0;
    frac = 0;
    v = v & 64'hFFFFFFFF;
    if (v == 0) return 0;
    while (e < 31 && (v >> (e + 1)) != 0) e++;
    m = v << (31 - e);
    for (int i = 0; i < 20; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return (longint'(e) << 20) | frac;
  endfunction

  function automatic longint unsigned ln_from_log2(input longint unsigned d);
    return (d * 64'd2977044472) >> 32;
  endfunction

  task automatic ssa_predict(input req_t r, output step_res_t res);
    longint unsigned gp, end_t, held, x, birth, death, total, nl, dt, t, th, tl, p1, p2, hi, lo;
    longint unsigned lk, lx, lnkx;
    int unsigned first, cnt;
    bit sat, divide;
    gp = grid_pts;
    end_t = gp * grid_step;
    first = cur_gidx;
    cnt = 0;
    held = 0;
    if (r.op == 1'b0) begin
      cur_pop = init_pop;
      cur_time = 0;
      first = 0;
      cnt = 1;
      held = cur_pop;
      cur_gidx = 1;
      is_running = (cur_pop != 0) && (end_t > 0);
    end else if (is_running) begin
      x = cur_pop;
      birth = 0;
      if (x < capacity && x != 0) begin
        lk = log2_frac(capacity);
        lx = log2_frac(x);
        lnkx = (lk > lx) ? ln_from_log2(lk - lx) : 0;
        birth = (((coef_f * x) >> 10) * lnkx) >> 10;
      end
      death = coef_g * x;
      total = birth + death;
      if (total == 0) begin
        // no reaction possible: fill the rest of the grid and stop
        while (cur_gidx < gp) cur_gidx++;
        cnt = cur_gidx - first;
        held = x;
        cur_time = 64'hFFFFFFFF;
        is_running = 1'b0;
      end else begin
        nl = ln_from_log2((64'd32 << 20) - log2_frac(r.u_time == 0 ? 1 : r.u_time));
        dt = (nl << 16) / total;
        t = cur_time + dt;
        if (t >= 64'hFFFFFFFF) t = 64'hFFFFFFFF;
        sat = (t == 64'hFFFFFFFF);
        while (cur_gidx < gp && (sat || t > longint'(cur_gidx) * grid_step)) cur_gidx++;
        cnt = cur_gidx - first;
        if (cnt > 0) held = x;
        cur_time = t;
        th = total >> 32;
        tl = total & 64'hFFFFFFFF;
        p1 = r.u_pick * th;
        p2 = r.u_pick * tl;
        hi = p1 + (p2 >> 32);
        lo = p2 & 64'hFFFFFFFF;
        divide = (hi < birth) || (hi == birth && lo == 0);
        if (divide) begin
          if (x < 64'hFFFFFF) x++;
        end else if (x > 0) begin
          x--;
        end
        cur_pop = x;
        if (x == 0 || sat || t >= end_t) is_running = 1'b0;
      end
    end
    res.pop_after = cur_pop[POP_W-1:0];
    res.held_pop = held[POP_W-1:0];
    res.grid_first = first[GIDX_W-1:0];
    res.grid_count = cnt[CNT_W-1:0];
    res.time_after = cur_time[TIME_W-1:0];
    res.finished = !is_running;
  endtask

  // driver: bursts with random gaps
  int unsigned burst_left = 4;
  int unsigned gap_left = 0;
  always @(posedge clk) begin
    req_t nxt;
    req_t cur;
    step_res_t res;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        cur.op = in_tuser[0];
        cur.u_time = in_tdata[31:0];
        cur.u_pick = in_tdata[63:32];
        ssa_predict(cur, res);
        pending_results.push_back(res);
      end
      if (!(in_tvalid && !in_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          nxt = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tuser[0] <= nxt.op;
          in_tdata <= {nxt.u_pick, nxt.u_time};
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result; the result stall pattern changes when the mode period ends
  int unsigned stall_mode = 0;
  int unsigned mode_cycles = 0;
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    step_res_t exp_r;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with none expected, got %h", $realtime, out_tdata);
          fail_count++;
        end else begin
          exp_r = pending_results.pop_front();
          if (out_tdata[23:0] !== exp_r.pop_after) begin
            $display("%0t: pop_after expected %0d got %0d", $realtime, exp_r.pop_after,
                     out_tdata[23:0]);
            fail_count++;
          end
          if (out_tdata[47:24] !== exp_r.held_pop) begin
            $display("%0t: held_pop expected %0d got %0d", $realtime, exp_r.held_pop,
                     out_tdata[47:24]);
            fail_count++;
          end
          if (out_tdata[57:48] !== exp_r.grid_first) begin
            $display("%0t: grid_first expected %0d got %0d", $realtime, exp_r.grid_first,
                     out_tdata[57:48]);
            fail_count++;
          end
          if (out_tdata[68:58] !== exp_r.grid_count) begin
            $display("%0t: grid_count expected %0d got %0d", $realtime, exp_r.grid_count,
                     out_tdata[68:58]);
            fail_count++;
          end
          if (out_tdata[100:69] !== exp_r.time_after) begin
            $display("%0t: time_after expected %h got %h", $realtime, exp_r.time_after,
                     out_tdata[100:69]);
            fail_count++;
          end
          if (out_tdata[101] !== exp_r.finished) begin
            $display("%0t: finished expected %b got %b", $realtime, exp_r.finished,
                     out_tdata[101]);
            fail_count++;
          end
        end
      end
      if (mode_cycles == 0) begin
        mode_cycles = 300;
        stall_mode = $urandom_range(0, 3);
      end
      mode_cycles--;
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 1) == 1);
        2: out_tready <= (mode_cycles % 4 == 0);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            out_tready <= 1'b0;
          end else begin
            stall_left = $urandom_range(0, 60);
            out_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  // watchdog on handshake progress
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("gompertz_birth_death_ssa_step verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint unsigned val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[31:0];
    case (idx)
      REG_DIV_COEF:   coef_f = val & 64'hFFFFFF;
      REG_DEATH_COEF: coef_g = val & 64'hFFFFFF;
      REG_CAPACITY:   capacity = val & 64'hFFFFFF;
      REG_INIT_POP:   init_pop = val & 64'hFFFFFF;
      REG_GRID_STEP:  grid_step = val & 64'hFFFFFFFF;
      REG_GRID_PTS:   grid_pts = val & 64'h3FF;
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic write_all(input longint unsigned f, input longint unsigned g,
                           input longint unsigned k, input longint unsigned x0,
                           input longint unsigned gs, input longint unsigned gp);
    write_reg(REG_DIV_COEF, f);
    write_reg(REG_DEATH_COEF, g);
    write_reg(REG_CAPACITY, k);
    write_reg(REG_INIT_POP, x0);
    write_reg(REG_GRID_STEP, gs);
    write_reg(REG_GRID_PTS, gp);
  endtask

  // sampled away from the rising edge so driver updates have settled
  task automatic drain;
    while (pending_reqs.size() > 0 || in_tvalid || pending_results.size() > 0) @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic push_req(input logic op, input logic [31:0] ut, input logic [31:0] up);
    req_t r;
    r.op = op;
    r.u_time = ut;
    r.u_pick = up;
    pending_reqs.push_back(r);
  endtask

  function automatic logic [31:0] rand_u_time();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFFFFFF;
      default: return $urandom;
    endcase
  endfunction

  // a start followed by a run of steps, with some noise items mixed in
  task automatic push_realization(input int unsigned nsteps);
    push_req(1'b0, $urandom, $urandom);
    for (int i = 0; i < nsteps; i++) begin
      if ($urandom_range(0, 19) == 0) push_req(1'($urandom_range(0, 1)), $urandom, $urandom);
      else push_req(1'b1, rand_u_time(), $urandom);
    end
  endtask

  task automatic random_config;
    longint unsigned f, g, k, x0, gs, gp;
    f = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 24'hFFFFFF) : $urandom_range(0, 1 << 22);
    g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 1 << 20);
    k = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 24'hFFFFFF) : $urandom_range(1, 3000);
    x0 = $urandom_range(0, (k > 100) ? 100 : k + 3);
    gs = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(1, 1 << 17);
    gp = $urandom_range(1, 300);
    write_all(f, g, k, x0, gs, gp);
  endtask

  initial begin
    coef_f = 1048576; coef_g = 0; capacity = 100000; init_pop = 100;
    grid_step = 6554; grid_pts = 300;
    cur_pop = 0; cur_time = 0; cur_gidx = 0; is_running = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: step before any start, then u extremes
    push_req(1'b1, 32'd5, 32'd5);
    push_req(1'b0, 32'd0, 32'd0);
    push_req(1'b1, 32'd1, 32'd0);
    push_req(1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF);
    push_req(1'b1, 32'd0, 32'h80000000);
    push_req(1'b1, 32'h80000000, 32'h7FFFFFFF);
    drain();

    // zero rate: fill the rest of the grid, then idle steps
    write_all(0, 0, 50, 7, 100, 20);
    push_req(1'b0, 32'd3, 32'd3);
    push_req(1'b1, 32'd3, 32'd3);
    push_req(1'b1, 32'd3, 32'd3);
    drain();
    // population above capacity with no death, zero population, zero end time
    write_all(24'hFFFFFF, 0, 1, 5, 1000, 10);
    push_req(1'b0, 32'd1, 32'd1);
    push_req(1'b1, 32'd1, 32'd1);
    drain();
    write_reg(REG_INIT_POP, 0);
    push_req(1'b0, 32'd1, 32'd1);
    push_req(1'b1, 32'd1, 32'd1);
    drain();
    write_reg(REG_GRID_PTS, 0);
    write_reg(REG_INIT_POP, 4);
    push_req(1'b0, 32'd1, 32'd1);
    push_req(1'b1, 32'd1, 32'd1);
    drain();

    // extremes: huge grid, fast deaths at full population
    write_all(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF, 1023);
    push_realization(6);
    drain();
    // fine grid with slow rates: many grid points per step and time saturation
    write_all(1, 1, 24'hFFFFFF, 2, 1, 1023);
    push_realization(4);
    drain();
    // a full run, then the grid shrinks to one point for a fresh start and a step
    write_all(1 << 20, 0, 100000, 100, 6554, 300);
    push_realization(30);
    drain();
    write_reg(REG_GRID_PTS, 1);
    push_realization(0);
    push_req(1'b1, 32'd7, 32'd7);
    drain();

    for (int phase = 0; phase < 9; phase++) begin
      random_config();
      for (int n = 0; n < 200; ) begin
        int unsigned len;
        len = $urandom_range(1, 40);
        push_realization(len);
        n += len + 1;
      end
      drain();
    end

    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("gompertz_birth_death_ssa_step verification clean");
    end else begin
      $display("gompertz_birth_death_ssa_step verification failed");
    end
    $finish;
  end

endmodule
